// File: sv/tlrq_pkg.sv
// Package: shared types, constants and class helper for the ready queue scheduler
`timescale 1ns / 1ps
package tlrq_pkg;

  // slot table sizing
  localparam int TASK_SLOTS    = 8;
  localparam int PROCESS_SLOTS = 16;
  localparam int NSLOTS        = TASK_SLOTS + PROCESS_SLOTS;
  localparam int SLOT_W        = 5;
  localparam int FUN_W         = 5;
  localparam logic [SLOT_W-1:0] HW_SLOT = SLOT_W'(TASK_SLOTS - 1);
  localparam logic [FUN_W-1:0] FUN_RESET = FUN_W'(2);

  // APB register map (word index taken from paddr[2])
  localparam int PADDR_W = 3;
  localparam logic REG_FIRST_USER = 1'b0;

  // link or head pointer: nil flag plus slot
  typedef struct packed {
    logic              nil;
    logic [SLOT_W-1:0] slot;
  } link_t;

  localparam link_t LINK_NIL = '{nil: 1'b1, slot: '0};

  typedef enum logic [1:0] {
    Q_TASK   = 2'd0,
    Q_SERVER = 2'd1,
    Q_USER   = 2'd2
  } qid_t;

  typedef enum logic [1:0] {
    K_READY   = 2'd0,
    K_UNREADY = 2'd1,
    K_SCHED   = 2'd2,
    K_PICK    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RDY_FIN,
    S_UN_HEAD,
    S_UN_WALK,
    S_UN_LINK,
    S_SCHED,
    S_SCHED2,
    S_PICK,
    S_DONE
  } st_t;

  // user: slot at or above TASK_SLOTS + first_user_number
  function automatic logic is_user(input logic [SLOT_W-1:0] slot,
                                   input logic [FUN_W-1:0] fun);
    logic [SLOT_W:0] lim;
    lim = (SLOT_W+1)'(TASK_SLOTS) + (SLOT_W+1)'(fun);
    return ({1'b0, slot} >= (SLOT_W+1)'(TASK_SLOTS)) && ({1'b0, slot} >= lim);
  endfunction

  function automatic qid_t class_of(input logic [SLOT_W-1:0] slot,
                                    input logic [FUN_W-1:0] fun);
    qid_t q;
    if ({1'b0, slot} < (SLOT_W+1)'(TASK_SLOTS)) q = Q_TASK;
    else if (!is_user(slot, fun)) q = Q_SERVER;
    else q = Q_USER;
    return q;
  endfunction

endpackage

// File: sv/three_level_ready_queue_scheduler.sv
// Top level: three linked ready queues over a slot table, walked by a small sequencer
//
//  channel | dir | handshake          | beat
//  --------+-----+--------------------+---------------------------------------------
//  in      | in  | in_valid/in_ready  | kind, process_slot
//  out     | out | out_valid/out_ready| running/previous/billed slot, idle flags,
//          |     |                    | was_queued
//  apb     | in  | psel/penable       | first_user_number at word 0
//
// One beat in flight. Idle takes a beat into decode; a beat that changes nothing then goes to
// done, ready adds a finishing step, pick a pick step, unready of a head a head update and a
// pick, sched two link writes and a pick; unready further down reads one link per walk step
// and adds a relink on a hit. The link memory's registered read sets one link per cycle.
// Result stays on the outputs until out_ready; in_ready is low meanwhile and in reset.
// Synchronous reset empties all queues and sets the run state to idle.
`timescale 1ns / 1ps
module three_level_ready_queue_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  // input beats
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [4:0]                  process_slot,
  // result beats
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [4:0]                  running_slot,
  output logic                        running_idle,
  output logic [4:0]                  previous_slot,
  output logic                        previous_idle,
  output logic [4:0]                  billed_slot,
  output logic                        was_queued,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlrq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  tlrq_pkg::st_t  state, state_next;
  tlrq_pkg::kind_t kind_q;
  logic [tlrq_pkg::SLOT_W-1:0] slot_q;
  logic [tlrq_pkg::SLOT_W-1:0] cur_ptr;
  logic [tlrq_pkg::FUN_W-1:0]  first_user_number;

  tlrq_pkg::link_t queue_head [3];
  logic [tlrq_pkg::SLOT_W-1:0] queue_tail [3];
  logic [tlrq_pkg::NSLOTS-1:0] queued;

  logic [tlrq_pkg::SLOT_W-1:0] cur_slot, prev_slot, billed;
  logic cur_idle, prev_idle, removed;

  // link memory
  tlrq_pkg::link_t link_mem [tlrq_pkg::NSLOTS];
  tlrq_pkg::link_t rd_data;
  tlrq_pkg::link_t mem_wdata;
  logic [tlrq_pkg::SLOT_W-1:0] mem_waddr, mem_raddr;
  logic mem_we;

  tlrq_pkg::qid_t q;
  logic in_range;
  tlrq_pkg::link_t pick_head;
  logic apb_wr;

  // decode of the latched beat
  assign q        = tlrq_pkg::class_of(slot_q, first_user_number);
  assign in_range = int'(slot_q) < tlrq_pkg::NSLOTS;

  // highest non-empty queue head
  always_comb begin
    if (!queue_head[tlrq_pkg::Q_TASK].nil) pick_head = queue_head[tlrq_pkg::Q_TASK];
    else if (!queue_head[tlrq_pkg::Q_SERVER].nil) pick_head = queue_head[tlrq_pkg::Q_SERVER];
    else pick_head = queue_head[tlrq_pkg::Q_USER];
  end

  // APB
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && (paddr[2] == tlrq_pkg::REG_FIRST_USER);
  assign prdata = (paddr[2] == tlrq_pkg::REG_FIRST_USER) ?
                  {{(32-tlrq_pkg::FUN_W){1'b0}}, first_user_number} : 32'd0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tlrq_pkg::S_IDLE: begin
        if (in_valid) state_next = tlrq_pkg::S_DECODE;
      end
      tlrq_pkg::S_DECODE: begin
        case (kind_q)
          tlrq_pkg::K_READY: begin
            if (!in_range || queued[slot_q]) state_next = tlrq_pkg::S_DONE;
            else state_next = tlrq_pkg::S_RDY_FIN;
          end
          tlrq_pkg::K_UNREADY: begin
            if (!in_range || queue_head[q].nil) state_next = tlrq_pkg::S_DONE;
            else if (queue_head[q].slot == slot_q) state_next = tlrq_pkg::S_UN_HEAD;
            else state_next = tlrq_pkg::S_UN_WALK;
          end
          tlrq_pkg::K_SCHED: begin
            if (queue_head[tlrq_pkg::Q_USER].nil) state_next = tlrq_pkg::S_DONE;
            else state_next = tlrq_pkg::S_SCHED;
          end
          default: state_next = tlrq_pkg::S_PICK;
        endcase
      end
      tlrq_pkg::S_RDY_FIN: state_next = tlrq_pkg::S_DONE;
      tlrq_pkg::S_UN_HEAD: state_next = tlrq_pkg::S_PICK;
      tlrq_pkg::S_UN_WALK: begin
        if (rd_data.nil) state_next = tlrq_pkg::S_DONE;
        else if (rd_data.slot == slot_q) state_next = tlrq_pkg::S_UN_LINK;
      end
      tlrq_pkg::S_UN_LINK: state_next = tlrq_pkg::S_DONE;
      tlrq_pkg::S_SCHED:   state_next = tlrq_pkg::S_SCHED2;
      tlrq_pkg::S_SCHED2:  state_next = tlrq_pkg::S_PICK;
      tlrq_pkg::S_PICK:    state_next = tlrq_pkg::S_DONE;
      tlrq_pkg::S_DONE: begin
        if (out_ready) state_next = tlrq_pkg::S_IDLE;
      end
      default: state_next = tlrq_pkg::S_IDLE;
    endcase
  end

  // outputs and memory port controls
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = tlrq_pkg::LINK_NIL;
    mem_raddr = '0;
    case (state)
      tlrq_pkg::S_IDLE: in_ready = !rst;
      tlrq_pkg::S_DECODE: begin
        case (kind_q)
          tlrq_pkg::K_READY: begin
            // append behind the old tail
            if (in_range && !queued[slot_q] && !queue_head[q].nil) begin
              mem_we    = 1'b1;
              mem_waddr = queue_tail[q];
              mem_wdata = '{nil: 1'b0, slot: slot_q};
            end
          end
          tlrq_pkg::K_UNREADY: mem_raddr = queue_head[q].slot;
          tlrq_pkg::K_SCHED:   mem_raddr = queue_head[tlrq_pkg::Q_USER].slot;
          default: mem_raddr = '0;
        endcase
      end
      tlrq_pkg::S_RDY_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = slot_q;
      end
      tlrq_pkg::S_UN_WALK: begin
        // follow the chain; on a hit fetch the victim's own link
        mem_raddr = (rd_data.slot == slot_q) ? slot_q : rd_data.slot;
      end
      tlrq_pkg::S_UN_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = cur_ptr;
        mem_wdata = rd_data;
      end
      tlrq_pkg::S_SCHED: begin
        mem_we    = 1'b1;
        mem_waddr = queue_tail[tlrq_pkg::Q_USER];
        mem_wdata = '{nil: 1'b0, slot: cur_ptr};
      end
      tlrq_pkg::S_SCHED2: begin
        mem_we    = 1'b1;
        mem_waddr = cur_ptr;
      end
      tlrq_pkg::S_DONE: out_valid = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  // link memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    rd_data <= link_mem[mem_raddr];
  end

  // sequencer and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= tlrq_pkg::S_IDLE;
      first_user_number <= tlrq_pkg::FUN_RESET;
      queued            <= '0;
      queue_head[0]     <= tlrq_pkg::LINK_NIL;
      queue_head[1]     <= tlrq_pkg::LINK_NIL;
      queue_head[2]     <= tlrq_pkg::LINK_NIL;
      cur_slot          <= tlrq_pkg::HW_SLOT;
      cur_idle          <= 1'b1;
      prev_slot         <= tlrq_pkg::HW_SLOT;
      prev_idle         <= 1'b1;
      billed            <= tlrq_pkg::HW_SLOT;
      removed           <= 1'b0;
    end else begin
      state <= state_next;
      if (apb_wr) first_user_number <= pwdata[tlrq_pkg::FUN_W-1:0];
      case (state)
        tlrq_pkg::S_IDLE: begin
          if (in_valid) begin
            kind_q  <= tlrq_pkg::kind_t'(kind);
            slot_q  <= process_slot;
            removed <= 1'b0;
          end
        end
        tlrq_pkg::S_DECODE: begin
          if (kind_q == tlrq_pkg::K_UNREADY) cur_ptr <= queue_head[q].slot;
          else cur_ptr <= queue_head[tlrq_pkg::Q_USER].slot;
        end
        tlrq_pkg::S_RDY_FIN: begin
          if (queue_head[q].nil) queue_head[q] <= '{nil: 1'b0, slot: slot_q};
          queue_tail[q]  <= slot_q;
          queued[slot_q] <= 1'b1;
        end
        tlrq_pkg::S_UN_HEAD: begin
          queue_head[q]  <= rd_data;
          queued[slot_q] <= 1'b0;
          removed        <= 1'b1;
        end
        tlrq_pkg::S_UN_WALK: begin
          if (!rd_data.nil && rd_data.slot != slot_q) cur_ptr <= rd_data.slot;
        end
        tlrq_pkg::S_UN_LINK: begin
          // victim was the tail: predecessor becomes the tail
          if (rd_data.nil) queue_tail[q] <= cur_ptr;
          queued[slot_q] <= 1'b0;
          removed        <= 1'b1;
        end
        tlrq_pkg::S_SCHED: begin
          // single entry rotates onto itself
          if (queue_tail[tlrq_pkg::Q_USER] == cur_ptr)
            queue_head[tlrq_pkg::Q_USER] <= '{nil: 1'b0, slot: cur_ptr};
          else
            queue_head[tlrq_pkg::Q_USER] <= rd_data;
          queue_tail[tlrq_pkg::Q_USER] <= cur_ptr;
        end
        tlrq_pkg::S_PICK: begin
          prev_slot <= cur_slot;
          prev_idle <= cur_idle;
          if (!pick_head.nil) begin
            cur_slot <= pick_head.slot;
            cur_idle <= 1'b0;
            if (tlrq_pkg::is_user(pick_head.slot, first_user_number))
              billed <= pick_head.slot;
          end else begin
            cur_slot <= tlrq_pkg::HW_SLOT;
            cur_idle <= 1'b1;
            billed   <= tlrq_pkg::HW_SLOT;
          end
        end
        default: removed <= removed;
      endcase
    end
  end

  assign running_slot  = cur_slot;
  assign running_idle  = cur_idle;
  assign previous_slot = prev_slot;
  assign previous_idle = prev_idle;
  assign billed_slot   = billed;
  assign was_queued    = removed;

endmodule

// File: sv/tlrq_checker.sv
// Checker: port-level properties of the ready queue scheduler, bound to the top level
`timescale 1ns / 1ps
module tlrq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] running_slot,
  input logic       running_idle,
  input logic [4:0] previous_slot,
  input logic       previous_idle,
  input logic [4:0] billed_slot
);

  // one beat in flight: never ready while a result is shown
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // an accepted beat closes the input side at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after accept");

  // idle run shows the hardware slot and bills it
  a_idle_run: assert property (@(posedge clk) disable iff (rst)
    running_idle |-> (running_slot == tlrq_pkg::HW_SLOT &&
                      billed_slot == tlrq_pkg::HW_SLOT))
    else $error("idle run without hardware slot");

  a_idle_prev: assert property (@(posedge clk) disable iff (rst)
    previous_idle |-> (previous_slot == tlrq_pkg::HW_SLOT))
    else $error("idle previous run without hardware slot");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(running_slot) &&
                                   $stable(billed_slot)))
    else $error("result changed while stalled");

endmodule

bind three_level_ready_queue_scheduler tlrq_checker u_tlrq_checker (.*);
